/* rtl/core/sgmpa_pkg.sv */
// Shared types and constants for the SGM path cost aggregation unit.
`timescale 1ns / 1ps

package sgmpa_pkg;

   localparam int COST_WIDTH  = 16;
   localparam int PATH_WIDTH  = 17;
   localparam int DISP_WIDTH  = 6;
   localparam int PEN_WIDTH   = 16;
   localparam int COUNT_WIDTH = 7;

   localparam logic [PATH_WIDTH-1:0] COST_MAX = 17'h1FFFF;

   localparam logic [PEN_WIDTH-1:0]   STEP_PENALTY_RESET    = 16'd10;
   localparam logic [PEN_WIDTH-1:0]   JUMP_PENALTY_RESET    = 16'd120;
   localparam logic [COUNT_WIDTH-1:0] DISPARITY_COUNT_RESET = 7'd64;

   localparam logic [1:0] CSR_STEP_PENALTY    = 2'd0;
   localparam logic [1:0] CSR_JUMP_PENALTY    = 2'd1;
   localparam logic [1:0] CSR_DISPARITY_COUNT = 2'd2;

   typedef struct packed {
      logic [PEN_WIDTH-1:0]   step_penalty;
      logic [PEN_WIDTH-1:0]   jump_penalty;
      logic [COUNT_WIDTH-1:0] disparity_count;
   } cfg_type;

   typedef struct packed {
      logic [PATH_WIDTH-1:0] path;
      logic                  in_use;
      logic                  last;
   } calc_out_type;

endpackage

/* rtl/core/sgm_path_cost_aggregation_unit.sv */
// Top level of the SGM path cost aggregation unit for one scan direction.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: match_cost, disparity; tuser: line_start
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: path_cost, out_disparity; tlast: pixel_done
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
//  One request per cycle sustained while rsp is not stalled; rsp_tvalid rises once the
//  request has passed the input register, then the result register.
//  The path vector reads (three neighbours) are issued at acceptance from two parity
//  memories; a write on the same edge to the bank being read (end of pixel) is forwarded.
//  Reset is synchronous; the path store needs no clearing pass.
//  A stalled rsp holds the stage register, which in turn drops req_tready.
`timescale 1ns / 1ps

module sgm_path_cost_aggregation_unit #(
   parameter int MAX_DISPARITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] match_cost, [21:16] disparity, [23:22] zero
   input  logic        req_tuser,   // [0] line_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] path_cost, [22:17] out_disparity, [23] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int HALF = (MAX_DISPARITY + 1) / 2;
   localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int IW   = (AW + 1 > 7) ? AW + 1 : 7;
   localparam int PW   = sgmpa_pkg::PATH_WIDTH;
   localparam int DW   = sgmpa_pkg::DISP_WIDTH;

   sgmpa_pkg::cfg_type      cfg;
   sgmpa_pkg::calc_out_type calc;

   logic          req_accept;
   logic          a_adv;
   logic          wr_any;
   logic          flip_now;
   logic          rd_bank;
   logic [IW-1:0] d_ext;
   logic [IW-1:0] dm1;
   logic [IW-1:0] dp1;
   logic [IW-1:0] a_d_ext;
   logic [AW:0]   even_rd0;
   logic [AW:0]   odd_rd0;
   logic [AW:0]   rd1;
   logic [AW:0]   wr_addr;
   logic [PW-1:0] even_q0;
   logic [PW-1:0] even_q1;
   logic [PW-1:0] odd_q0;
   logic [PW-1:0] odd_q1;
   logic [PW-1:0] mem_center;
   logic [PW-1:0] mem_left;
   logic [PW-1:0] mem_right;
   logic [PW-1:0] center_cost;
   logic [PW-1:0] left_cost;
   logic [PW-1:0] right_cost;
   logic [PW-1:0] run_min_upd;

   logic                               a_valid_ff, a_valid_in;
   logic [sgmpa_pkg::COST_WIDTH-1:0]   a_cost_ff;
   logic [DW-1:0]                      a_d_ff;
   logic                               a_first_ff;
   logic                               fwd_c_ff, fwd_l_ff, fwd_r_ff;
   logic [PW-1:0]                      fwd_value_ff;
   logic                               bank_select_ff;
   logic [PW-1:0]                      previous_minimum_ff;
   logic [PW-1:0]                      running_minimum_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [23:0]                        rsp_data_ff;
   logic                               rsp_last_ff;

   sgmpa_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // stage control
   assign a_adv      = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_adv;
   assign req_accept = req_tvalid && req_tready;
   assign a_valid_in = req_accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   assign wr_any   = a_adv && calc.in_use;
   assign flip_now = wr_any && calc.last;
   // previous bank as seen after the in-flight request completes
   assign rd_bank  = ~(bank_select_ff ^ flip_now);

   // read addresses: even memory holds even disparities, odd memory odd ones
   assign d_ext    = IW'(req_tdata[21:16]);
   assign dm1      = d_ext - IW'(1);
   assign dp1      = d_ext + IW'(1);
   assign even_rd0 = {rd_bank, d_ext[AW:1]};
   assign odd_rd0  = req_tdata[16] ? {rd_bank, d_ext[AW:1]} : {rd_bank, dm1[AW:1]};
   assign rd1      = {rd_bank, dp1[AW:1]};

   assign a_d_ext  = IW'(a_d_ff);
   assign wr_addr  = {bank_select_ff, a_d_ext[AW:1]};

   sgmpa_path_mem #(.ADDR_WIDTH(AW)) u_mem_even (
      .clock    (clock),
      .wr_en    (wr_any && !a_d_ff[0]),
      .wr_addr  (wr_addr),
      .wr_data  (calc.path),
      .rd_en    (req_accept),
      .rd_addr0 (even_rd0),
      .rd_addr1 (rd1),
      .rd_data0 (even_q0),
      .rd_data1 (even_q1)
   );

   sgmpa_path_mem #(.ADDR_WIDTH(AW)) u_mem_odd (
      .clock    (clock),
      .wr_en    (wr_any && a_d_ff[0]),
      .wr_addr  (wr_addr),
      .wr_data  (calc.path),
      .rd_en    (req_accept),
      .rd_addr0 (odd_rd0),
      .rd_addr1 (rd1),
      .rd_data0 (odd_q0),
      .rd_data1 (odd_q1)
   );

   assign mem_center  = a_d_ff[0] ? odd_q0  : even_q0;
   assign mem_left    = a_d_ff[0] ? even_q0 : odd_q0;
   assign mem_right   = a_d_ff[0] ? even_q1 : odd_q1;
   assign center_cost = fwd_c_ff ? fwd_value_ff : mem_center;
   assign left_cost   = fwd_l_ff ? fwd_value_ff : mem_left;
   assign right_cost  = fwd_r_ff ? fwd_value_ff : mem_right;

   sgmpa_cost_calc #(.MAX_DISPARITY(MAX_DISPARITY)) u_calc (
      .cfg              (cfg),
      .match_cost       (a_cost_ff),
      .disparity        (a_d_ff),
      .line_start       (a_first_ff),
      .center_cost      (center_cost),
      .left_cost        (left_cost),
      .right_cost       (right_cost),
      .previous_minimum (previous_minimum_ff),
      .result           (calc)
   );

   assign run_min_upd  = (calc.path < running_minimum_ff) ? calc.path : running_minimum_ff;
   assign rsp_valid_in = a_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff          <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         bank_select_ff      <= 1'b0;
         previous_minimum_ff <= '0;
         running_minimum_ff  <= sgmpa_pkg::COST_MAX;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_any) begin
            if (calc.last) begin
               previous_minimum_ff <= run_min_upd;
               running_minimum_ff  <= sgmpa_pkg::COST_MAX;
               bank_select_ff      <= ~bank_select_ff;
            end else begin
               running_minimum_ff  <= run_min_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_cost_ff    <= req_tdata[15:0];
         a_d_ff       <= req_tdata[21:16];
         a_first_ff   <= req_tuser;
         fwd_c_ff     <= wr_any && flip_now && (d_ext == a_d_ext);
         fwd_l_ff     <= wr_any && flip_now && (dm1 == a_d_ext);
         fwd_r_ff     <= wr_any && flip_now && (dp1 == a_d_ext);
         fwd_value_ff <= calc.path;
      end
      if (a_adv) begin
         rsp_data_ff <= {1'b0, a_d_ff, calc.path};
         rsp_last_ff <= calc.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // end of pixel swaps the banks
   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      (a_adv && calc.in_use && calc.last) |=> (bank_select_ff != $past(bank_select_ff)))
      else $error("bank select did not flip at end of pixel");

   a_run_min_restart: assert property (@(posedge clock) disable iff (reset)
      (a_adv && calc.in_use && calc.last) |=> (running_minimum_ff == sgmpa_pkg::COST_MAX))
      else $error("running minimum not restarted after pixel");

   a_line_start_cost: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_first_ff && calc.in_use) |-> (calc.path == PW'(a_cost_ff)))
      else $error("first pixel of line does not pass the raw cost");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !calc.in_use) |-> (calc.path == '0 && !calc.last))
      else $error("unused disparity produced a nonzero request");

   a_no_write_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(bank_select_ff)
         && $stable(running_minimum_ff))
      else $error("state changed while output stalled");

endmodule

/* rtl/core/sgmpa_csr_regs.sv */
// Configuration registers: penalties and disparity count.
`timescale 1ns / 1ps

module sgmpa_csr_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   output sgmpa_pkg::cfg_type   cfg
);

   sgmpa_pkg::cfg_type cfg_ff;
   sgmpa_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sgmpa_pkg::CSR_STEP_PENALTY:    cfg_in.step_penalty    = csr_data;
            sgmpa_pkg::CSR_JUMP_PENALTY:    cfg_in.jump_penalty    = csr_data;
            sgmpa_pkg::CSR_DISPARITY_COUNT: cfg_in.disparity_count =
               csr_data[sgmpa_pkg::COUNT_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_penalty    <= sgmpa_pkg::STEP_PENALTY_RESET;
         cfg_ff.jump_penalty    <= sgmpa_pkg::JUMP_PENALTY_RESET;
         cfg_ff.disparity_count <= sgmpa_pkg::DISPARITY_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/sgmpa_path_mem.sv */
// Path vector store for one disparity parity: one write port, two registered read ports.
`timescale 1ns / 1ps

module sgmpa_path_mem #(
   parameter int ADDR_WIDTH = 5
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_WIDTH:0]                wr_addr,
   input  logic [sgmpa_pkg::PATH_WIDTH-1:0]   wr_data,
   input  logic                               rd_en,
   input  logic [ADDR_WIDTH:0]                rd_addr0,
   input  logic [ADDR_WIDTH:0]                rd_addr1,
   output logic [sgmpa_pkg::PATH_WIDTH-1:0]   rd_data0,
   output logic [sgmpa_pkg::PATH_WIDTH-1:0]   rd_data1
);

   localparam int DEPTH = 2 << ADDR_WIDTH;

   logic [sgmpa_pkg::PATH_WIDTH-1:0] mem [0:DEPTH-1];
   logic [sgmpa_pkg::PATH_WIDTH-1:0] rd_data0_ff;
   logic [sgmpa_pkg::PATH_WIDTH-1:0] rd_data1_ff;

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem[rd_addr0];
         rd_data1_ff <= mem[rd_addr1];
      end
   end

endmodule

/* rtl/core/sgmpa_cost_calc.sv */
// Path cost recurrence for one disparity of one pixel.
`timescale 1ns / 1ps

module sgmpa_cost_calc #(
   parameter int MAX_DISPARITY = 64
) (
   input  sgmpa_pkg::cfg_type                 cfg,
   input  logic [sgmpa_pkg::COST_WIDTH-1:0]   match_cost,
   input  logic [sgmpa_pkg::DISP_WIDTH-1:0]   disparity,
   input  logic                               line_start,
   input  logic [sgmpa_pkg::PATH_WIDTH-1:0]   center_cost,
   input  logic [sgmpa_pkg::PATH_WIDTH-1:0]   left_cost,
   input  logic [sgmpa_pkg::PATH_WIDTH-1:0]   right_cost,
   input  logic [sgmpa_pkg::PATH_WIDTH-1:0]   previous_minimum,
   output sgmpa_pkg::calc_out_type            result
);

   localparam int CLOG = $clog2(MAX_DISPARITY + 1);
   localparam int CW   = (CLOG > sgmpa_pkg::COUNT_WIDTH) ? CLOG : sgmpa_pkg::COUNT_WIDTH;
   localparam int SW   = sgmpa_pkg::PATH_WIDTH + 1;
   localparam int VW   = SW + 2;

   logic [CW-1:0]       raw_count;
   logic [CW-1:0]       count;
   logic [CW-1:0]       disp_ext;
   logic                in_use;
   logic                is_last;
   logic                has_left;
   logic                has_right;
   logic [SW-1:0]       cand_center;
   logic [SW-1:0]       cand_left;
   logic [SW-1:0]       cand_right;
   logic [SW-1:0]       cand_jump;
   logic [SW-1:0]       best_a;
   logic [SW-1:0]       best_b;
   logic [SW-1:0]       best;
   logic signed [VW-1:0] value;
   logic [sgmpa_pkg::PATH_WIDTH-1:0] clamped;

   always_comb begin
      raw_count = CW'(cfg.disparity_count);
      if (raw_count < CW'(2)) begin
         count = CW'(2);
      end else if (raw_count > CW'(MAX_DISPARITY)) begin
         count = CW'(MAX_DISPARITY);
      end else begin
         count = raw_count;
      end
   end

   assign disp_ext  = CW'(disparity);
   assign in_use    = disp_ext < count;
   assign is_last   = disp_ext == (count - CW'(1));
   assign has_left  = disparity != '0;
   assign has_right = (disp_ext + CW'(1)) < count;

   assign cand_center = {1'b0, center_cost};
   assign cand_left   = {1'b0, left_cost} + SW'(cfg.step_penalty);
   assign cand_right  = {1'b0, right_cost} + SW'(cfg.step_penalty);
   assign cand_jump   = {1'b0, previous_minimum} + SW'(cfg.jump_penalty);

   always_comb begin
      best_a = (has_left && cand_left < cand_center) ? cand_left : cand_center;
      best_b = (has_right && cand_right < cand_jump) ? cand_right : cand_jump;
      best   = (best_b < best_a) ? best_b : best_a;
   end

   assign value = $signed(VW'(match_cost)) + $signed(VW'(best))
                - $signed(VW'(previous_minimum));

   always_comb begin
      if (value < 0) begin
         clamped = '0;
      end else if (value > $signed(VW'(sgmpa_pkg::COST_MAX))) begin
         clamped = sgmpa_pkg::COST_MAX;
      end else begin
         clamped = value[sgmpa_pkg::PATH_WIDTH-1:0];
      end
   end

   always_comb begin
      result.in_use = in_use;
      result.last   = in_use && is_last;
      if (!in_use) begin
         result.path = '0;
      end else if (line_start) begin
         result.path = sgmpa_pkg::PATH_WIDTH'(match_cost);
      end else begin
         result.path = clamped;
      end
   end

endmodule
